@@ rtl/core/bpt_pkg.sv @@
// Package with the shared types, register indexes and sequencer states of the compensation block.
package bpt_pkg;
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2 = 3'd3;
  localparam logic [2:0] REG_MC_MD = 3'd4;
  localparam logic [2:0] REG_OSS = 3'd5;

  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;

  typedef enum logic [1:0] {
    DIV_SIGNED,
    DIV_UNSIGNED
  } div_mode_t;

  typedef struct packed {
    logic start;
    div_mode_t mode;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T_MUL,
    S_T_X1,
    S_T_DIV,
    S_T_WAIT,
    S_T_END,
    S_P_SQ,
    S_P_SQS,
    S_P_M1,
    S_P_M2,
    S_P_M3,
    S_P_M4,
    S_P_B3,
    S_P_B4,
    S_P_B7,
    S_P_DIV,
    S_P_WAIT,
    S_P_Q,
    S_P_X1A,
    S_P_X1B,
    S_P_X2,
    S_P_END,
    S_OUT
  } seq_state_t;
endpackage

@@ rtl/core/baro_pressure_temp_compensation.sv @@
// Top level of the barometric temperature and pressure compensation block.
// Items enter on s_axis: tuser is the opcode (0 temperature, 1 pressure),
// tdata holds the 24-bit raw reading. One result leaves on m_axis per item:
// tuser carries the kind and the divide fault, tdata the signed value.
// Coefficients are written through the cfg channel with an index and data.
// A zero divisor ends the item early: the division is skipped and the
// item leaves with the divide fault set and a zero value. Both kinds use
// the shared divider and the single shared 32 by 32 multiplier, which
// the sequencer uses for at most one product per state.
// s_axis_tready is high only when the block is idle and no result waits.
// If the receiver stalls, the result is held in the output register and no
// further item is taken until it leaves.
// Reset clears all coefficients, the oversampling setting and the stored
// B5 to zero, and leaves the block idle with no result pending.
module baro_pressure_temp_compensation
  import bpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // raw_reading[23:0]
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result_value[31:0]
  output logic [1:0]  m_axis_tuser,   // divide_fault, result_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] coef_ac1_ac2, coef_ac3_ac4, coef_ac5_ac6, coef_b1_b2, coef_mc_md;
  logic [1:0]  oversampling;
  logic [31:0] b5;
  seq_state_t  state, state_next;
  logic        kind;
  logic [23:0] raw;
  logic [31:0] r0, r1, r2, r3, r4, r5, pval;
  logic        fault;
  logic [31:0] mul_a, mul_b, mul_p;
  div_ctrl_t   dctrl;
  div_stat_t   dstat;
  logic [31:0] dnum, dden, dq;
  logic        out_valid;
  logic [31:0] out_value;
  logic        out_kind, out_fault;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{coef_ac1_ac2[31]}}, coef_ac1_ac2[31:16]};
  assign ac2 = {{16{coef_ac1_ac2[15]}}, coef_ac1_ac2[15:0]};
  assign ac3 = {{16{coef_ac3_ac4[31]}}, coef_ac3_ac4[31:16]};
  assign ac4 = {16'd0, coef_ac3_ac4[15:0]};
  assign ac5 = {16'd0, coef_ac5_ac6[31:16]};
  assign ac6 = {16'd0, coef_ac5_ac6[15:0]};
  assign b1 = {{16{coef_b1_b2[31]}}, coef_b1_b2[31:16]};
  assign b2 = {{16{coef_b1_b2[15]}}, coef_b1_b2[15:0]};
  assign mc = {{16{coef_mc_md[31]}}, coef_mc_md[31:16]};
  assign md = {{16{coef_mc_md[15]}}, coef_mc_md[15:0]};

  logic [31:0] mul_sr11, mul_sr16, b3_val, p_corr;
  assign mul_sr11 = $signed(mul_p) >>> 11;
  assign mul_sr16 = $signed(mul_p) >>> 16;
  assign b3_val = $signed((((ac1 << 2) + r2) << oversampling) + 32'd2) >>> 2;
  assign p_corr = $signed(r0 + r1 + 32'd3791) >>> 4;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE) && !out_valid;
  assign mul_p = mul_a * mul_b;

  bpt_divider u_div (
    .clk(clk), .rst(rst), .ctrl(dctrl), .dividend(dnum), .divisor(dden),
    .stat(dstat), .quotient(dq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ac1_ac2 <= '0;
      coef_ac3_ac4 <= '0;
      coef_ac5_ac6 <= '0;
      coef_b1_b2 <= '0;
      coef_mc_md <= '0;
      oversampling <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AC1_AC2: coef_ac1_ac2 <= cfg_data;
        REG_AC3_AC4: coef_ac3_ac4 <= cfg_data;
        REG_AC5_AC6: coef_ac5_ac6 <= cfg_data;
        REG_B1_B2: coef_b1_b2 <= cfg_data;
        REG_MC_MD: coef_mc_md <= cfg_data;
        REG_OSS: oversampling <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    dctrl = '{start: 1'b0, mode: DIV_SIGNED};
    dnum = r0;
    dden = r1;
    unique case (state)
      S_IDLE: if (s_axis_tvalid && s_axis_tready)
        state_next = (s_axis_tuser == OP_TEMP) ? S_T_MUL : S_P_SQ;
      S_T_MUL: begin
        mul_a = {16'd0, raw[15:0]} - ac6;
        mul_b = ac5;
        state_next = S_T_X1;
      end
      S_T_X1: state_next = (r0 + md == 32'd0) ? S_T_END : S_T_DIV;
      S_T_DIV: begin
        dnum = mc << 11;
        dden = r0 + md;
        dctrl = '{start: 1'b1, mode: DIV_SIGNED};
        state_next = S_T_WAIT;
      end
      S_T_WAIT: if (dstat.done) state_next = S_T_END;
      S_T_END: state_next = S_OUT;
      S_P_SQ: begin
        mul_a = r0;
        mul_b = r0;
        state_next = S_P_SQS;
      end
      S_P_SQS: begin
        mul_a = b2;
        mul_b = r1;
        state_next = S_P_M1;
      end
      S_P_M1: begin
        mul_a = ac2;
        mul_b = r0;
        state_next = S_P_M2;
      end
      S_P_M2: begin
        mul_a = ac3;
        mul_b = r0;
        state_next = S_P_M3;
      end
      S_P_M3: begin
        mul_a = b1;
        mul_b = r1;
        state_next = S_P_M4;
      end
      S_P_M4: state_next = S_P_B3;
      S_P_B3: begin
        mul_a = ac4;
        mul_b = r4 + 32'd32768;
        state_next = S_P_B4;
      end
      S_P_B4: begin
        mul_a = r5;
        mul_b = 32'd50000 >> oversampling;
        state_next = S_P_B7;
      end
      S_P_B7: state_next = (r4 == 32'd0) ? S_P_END : S_P_DIV;
      S_P_DIV: begin
        dnum = r2[31] ? r2 : (r2 << 1);
        dden = r4;
        dctrl = '{start: 1'b1, mode: DIV_UNSIGNED};
        state_next = S_P_WAIT;
      end
      S_P_WAIT: if (dstat.done) state_next = S_P_Q;
      S_P_Q: begin
        mul_a = $signed(pval) >>> 8;
        mul_b = $signed(pval) >>> 8;
        state_next = S_P_X1A;
      end
      S_P_X1A: begin
        mul_a = r0;
        mul_b = 32'd3038;
        state_next = S_P_X1B;
      end
      S_P_X1B: begin
        mul_a = 32'd7357;
        mul_b = pval;
        state_next = S_P_X2;
      end
      S_P_X2: state_next = S_P_END;
      S_P_END: state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        kind <= s_axis_tuser;
        raw <= s_axis_tdata;
        fault <= 1'b0;
        r0 <= b5 - 32'd4000;
      end
      S_T_MUL: r0 <= $signed(mul_p) >>> 15;
      S_T_X1: r1 <= '0;
      S_T_WAIT: if (dstat.done) r1 <= dq;
      S_T_END: begin
        fault <= (r0 + md == 32'd0);
        pval <= r0 + r1;
      end
      S_P_SQ: r1 <= $signed(mul_p) >>> 12;
      S_P_SQS: r2 <= mul_sr11;
      S_P_M1: r2 <= r2 + mul_sr11;
      S_P_M2: r3 <= $signed(mul_p) >>> 13;
      S_P_M3: r4 <= $signed(mul_sr16 + r3 + 32'd2) >>> 2;
      S_P_M4: r5 <= ({8'd0, raw} >> (4'd8 - {2'd0, oversampling})) - b3_val;
      S_P_B3: r4 <= mul_p >> 15;
      S_P_B4: r2 <= mul_p;
      S_P_WAIT: if (dstat.done) pval <= r2[31] ? (dq << 1) : dq;
      S_P_Q: r0 <= mul_p;
      S_P_X1A: r0 <= $signed(mul_p) >>> 16;
      S_P_X1B: r1 <= $signed(32'd0 - mul_p) >>> 16;
      S_P_END: begin
        fault <= (r4 == 32'd0);
        pval <= pval + p_corr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b5 <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_T_END) b5 <= r0 + r1;
      if (state == S_OUT) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      out_kind <= kind;
      out_fault <= fault;
      if (fault) out_value <= '0;
      else if (kind == OP_TEMP) out_value <= $signed(pval + 32'd8) >>> 4;
      else out_value <= pval;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_value;
  assign m_axis_tuser = {out_fault, out_kind};
endmodule

@@ rtl/core/bpt_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, signed or unsigned.
module bpt_divider
  import bpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_ctrl_t   ctrl,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output div_stat_t   stat,
  output logic [31:0] quotient
);
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [5:0]  count;
  logic        busy;
  logic        done;
  logic [32:0] trial;
  logic [31:0] rem_sh;

  assign rem_sh = {rem[30:0], quo[31]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        count <= 6'd32;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      if (ctrl.mode == DIV_SIGNED) begin
        quo <= dividend[31] ? (32'd0 - dividend) : dividend;
        dvs <= divisor[31] ? (32'd0 - divisor) : divisor;
        neg <= dividend[31] ^ divisor[31];
      end else begin
        quo <= dividend;
        dvs <= divisor;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (32'd0 - quo) : quo;
  assign stat = '{busy: busy, done: done};
endmodule
